// ===== rtl/rap_pkg.sv =====
// shared types, constants and helpers of the roll attitude controller
package rap_pkg;

    localparam int DW    = 24;
    localparam int FB    = 16;
    localparam int DIVW  = 41;
    localparam int DVSW  = 20;

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] DEFL_MAX = 24'sd51472;

    localparam logic [17:0] TC_LOW   = 18'd6553;
    localparam logic [17:0] TC_HIGH  = 18'd196608;
    localparam logic [17:0] TC_RESET = 18'd6554;
    localparam logic [22:0] RATE_LIM_MIN = 23'd655;
    localparam logic [19:0] DT_MAX_US = 20'd500000;

    // dt by reciprocal: floor(n / 15625) = (n * DT_RECIP) >> DT_SHIFT for n below 2^29
    localparam logic [30:0] DT_BIAS  = 31'd15625;
    localparam logic [29:0] DT_RECIP = 30'd562949954;
    localparam int          DT_SHIFT = 43;

    typedef enum logic [2:0] {
        REG_TC    = 3'd0,
        REG_KP    = 3'd1,
        REG_KI    = 3'd2,
        REG_KD    = 3'd3,
        REG_ILIM  = 3'd4,
        REG_RLIM  = 3'd5,
        REG_SMIN  = 3'd6,
        REG_SMAX  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [17:0] roll_tau;
        logic [22:0] gain_p;
        logic [22:0] gain_i;
        logic [22:0] gain_d;
        logic [22:0] integral_limit;
        logic [22:0] rate_limit;
        logic [22:0] speed_min;
        logic [22:0] speed_max;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] target_roll;
        logic signed [23:0] measured_roll;
        logic signed [23:0] measured_rate;
        logic [22:0]        gain_scale;
        logic               hold_integral;
        logic [22:0]        airspeed;
        logic               airspeed_valid;
        logic [19:0]        elapsed_us;
        logic               clear_integral;
    } t_in_item;

    typedef struct packed {
        logic signed [16:0] deflection;
        logic signed [23:0] desired_rate;
        logic signed [23:0] rate_err;
    } t_out_item;

    // saturate a 26 bit signed sum to the data width
    function automatic logic signed [DW-1:0] f_sat(input logic signed [25:0] x);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'(VAL_MAX);
        lo = 26'(VAL_MIN);
        if (x > hi) return VAL_MAX;
        if (x < lo) return VAL_MIN;
        return x[DW-1:0];
    endfunction

endpackage

// ===== rtl/roll_attitude_pid_controller.sv =====
// roll attitude pid controller top level: sequencer around shared divider and multiplier
//
// usage:
//   input channel i_in_valid / o_in_stall carries one item (t_in_item) per control step.
//   output channel o_out_valid / i_out_stall returns one item (t_out_item) per input item.
//   configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), written while idle.
// sequence:
//   an item passes from accept to result through dt (reciprocal multiply, zero on a long gap),
//   the divider start, the 41 step restoring divider for the rate setpoint, nine products
//   through the one shared multiplier (a multiply state and a result state each), and the
//   load of the output register.
//   o_in_stall is high from accept until the result is loaded into the output register,
//   so one item is in flight at a time.
// reset:
//   synchronous active low reset clears the integrator, the stored unclamped output,
//   the configuration (time constant 0.1 s) and the output valid flag.
// back pressure:
//   while the receiver stalls, the output item holds; a new item may already be accepted
//   and processed, and it waits at the end of its sequence until the output register frees.
module roll_attitude_pid_controller
    import rap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DTS, S_SPS, S_SPW, S_MUL, S_MRES, S_OUT
    } t_state;

    t_cfg cfg;

    t_state r_state;
    t_in_item r_item;
    logic [3:0] r_step;
    logic signed [DW-1:0] r_integ, r_unc, r_dt, r_rsp, r_rerr;
    logic signed [DW-1:0] r_kir, r_kff, r_a, r_b, r_out;
    logic signed [16:0] r_cmd;
    logic r_out_valid;
    t_out_item r_out_data;

    logic div_start, div_done;
    logic [DIVW-1:0] div_dividend, div_quot;
    logic [DVSW-1:0] div_divisor;
    logic signed [DW-1:0] mul_a, mul_b, mul_p;

    logic signed [DW-1:0] err, sp_q, rlim;
    logic [DW-1:0] err_abs;
    logic [22:0] aspd;
    logic [23:0] smid;
    logic gate;
    logic signed [DW-1:0] id_adj, acc_next, ilim, out_sum;
    logic signed [DW-1:0] kff_raw;
    logic signed [DW-1:0] scale_s, tc_s;
    logic [30:0] dt_num;
    logic [29:0] dt_half;
    logic [59:0] dt_prod;

    rap_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    rap_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign scale_s = {1'b0, r_item.gain_scale};
    assign tc_s    = DW'(cfg.roll_tau);
    assign ilim    = {1'b0, cfg.integral_limit};
    assign rlim    = {1'b0, cfg.rate_limit};

    always_comb begin
        err = f_sat(26'(r_item.target_roll) - 26'(r_item.measured_roll));
        err_abs = err[DW-1] ? DW'(-25'(err)) : err;
        if (err == VAL_MIN) err_abs = {1'b1, {(DW-1){1'b0}}};

        div_start    = (r_state == S_SPS);
        div_dividend = DIVW'({err_abs, {FB{1'b0}}}) + DIVW'(cfg.roll_tau[17:1]);
        div_divisor  = DVSW'(cfg.roll_tau);

        // round(us * 2^16 / 1e6) = floor(((us * 2048 + 15625) >> 1) / 15625)
        dt_num  = {r_item.elapsed_us, 11'b0} + DT_BIAS;
        dt_half = dt_num[30:1];
        dt_prod = dt_half * DT_RECIP;

        // signed rate setpoint with saturation and optional limit
        if (err[DW-1]) begin
            if (div_quot >= DIVW'({1'b1, {(DW-1){1'b0}}})) sp_q = VAL_MIN;
            else sp_q = -div_quot[DW-1:0];
        end else begin
            if (div_quot > DIVW'(VAL_MAX)) sp_q = VAL_MAX;
            else sp_q = div_quot[DW-1:0];
        end
        if (cfg.rate_limit > RATE_LIM_MIN) begin
            if (sp_q > rlim) sp_q = rlim;
            if (sp_q < -rlim) sp_q = -rlim;
        end

        smid = (24'(cfg.speed_min) + 24'(cfg.speed_max)) >> 1;
        if (!r_item.airspeed_valid) aspd = smid[22:0];
        else if (r_item.airspeed < cfg.speed_min) aspd = cfg.speed_min;
        else aspd = r_item.airspeed;
        gate = !r_item.hold_integral && (r_kir > 0) && ({aspd, 1'b0} > 24'(cfg.speed_min));

        // anti-windup against last unclamped output
        id_adj = mul_p;
        if (r_unc < -DEFL_MAX) begin
            if (id_adj < 0) id_adj = '0;
        end else if (r_unc > DEFL_MAX) begin
            if (id_adj > 0) id_adj = '0;
        end
        acc_next = gate ? f_sat(26'(r_integ) + 26'(id_adj)) : r_integ;
        if (acc_next > ilim) acc_next = ilim;
        if (acc_next < -ilim) acc_next = -ilim;

        kff_raw = f_sat(26'(mul_p) - 26'({1'b0, cfg.gain_d}));
        out_sum = f_sat(26'(mul_p) + 26'(r_integ));

        case (r_step)
            4'd0: begin mul_a = {1'b0, cfg.gain_i}; mul_b = tc_s; end
            4'd1: begin
                mul_a = f_sat(26'({1'b0, cfg.gain_p}) - 26'(r_kir));
                mul_b = tc_s;
            end
            4'd2: begin mul_a = r_rerr; mul_b = r_kir; end
            4'd3: begin mul_a = r_a;    mul_b = r_dt; end
            4'd4: begin mul_a = r_a;    mul_b = scale_s; end
            4'd5: begin mul_a = r_rerr; mul_b = {1'b0, cfg.gain_d}; end
            4'd6: begin mul_a = r_b;    mul_b = scale_s; end
            4'd7: begin mul_a = r_rsp;  mul_b = r_kff; end
            default: begin mul_a = r_out; mul_b = scale_s; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_integ     <= '0;
            r_unc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        if (i_in_data.clear_integral) r_integ <= '0;
                        r_state <= S_DTS;
                    end
                end
                S_DTS: begin
                    if (r_item.elapsed_us > DT_MAX_US) r_dt <= '0;
                    else r_dt <= DW'(dt_prod[DT_SHIFT+15:DT_SHIFT]);
                    r_state <= S_SPS;
                end
                S_SPS: r_state <= S_SPW;
                S_SPW: begin
                    if (div_done) begin
                        r_rsp   <= sp_q;
                        r_rerr  <= f_sat(26'(sp_q) - 26'(r_item.measured_rate));
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_MRES;
                S_MRES: begin
                    case (r_step)
                        4'd0: r_kir <= mul_p;
                        4'd1: r_kff <= (kff_raw < 0) ? '0 : kff_raw;
                        4'd2, 4'd3: r_a <= mul_p;
                        4'd4: r_integ <= acc_next;
                        4'd5: r_b <= mul_p;
                        4'd6: r_out <= out_sum;
                        4'd7: r_out <= f_sat(26'(r_out) + 26'(mul_p));
                        default: begin
                            r_unc <= mul_p;
                            if (mul_p > DEFL_MAX) r_cmd <= 17'(DEFL_MAX);
                            else if (mul_p < -DEFL_MAX) r_cmd <= 17'(-DEFL_MAX);
                            else r_cmd <= mul_p[16:0];
                        end
                    endcase
                    if (r_step == 4'd8) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data.deflection   <= r_cmd;
                        r_out_data.desired_rate <= r_rsp;
                        r_out_data.rate_err     <= r_rerr;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output item appeared outside the sequence end");

    a_integ_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> (r_integ <= ilim && r_integ >= -ilim))
        else $error("integrator outside its clamp");

    a_defl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.deflection <= 17'(DEFL_MAX)
                         && o_out_data.deflection >= 17'(-DEFL_MAX)))
        else $error("deflection beyond 45 degrees");
`endif

endmodule

// ===== rtl/rap_cfg.sv =====
// configuration register file with time constant range check
module rap_cfg
    import rap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{roll_tau: TC_RESET, default: '0};
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TC: begin
                    if (i_cfg_data[17:0] > TC_LOW && i_cfg_data[17:0] < TC_HIGH)
                        r_cfg.roll_tau <= i_cfg_data[17:0];
                end
                REG_KP:   r_cfg.gain_p         <= i_cfg_data;
                REG_KI:   r_cfg.gain_i         <= i_cfg_data;
                REG_KD:   r_cfg.gain_d         <= i_cfg_data;
                REG_ILIM: r_cfg.integral_limit <= i_cfg_data;
                REG_RLIM: r_cfg.rate_limit     <= i_cfg_data;
                REG_SMIN: r_cfg.speed_min      <= i_cfg_data;
                REG_SMAX: r_cfg.speed_max      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/rap_mul.sv =====
// shared fixed point multiplier: round half up, saturate, registered
module rap_mul
    import rap_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_p
);

    logic signed [2*DW-1:0] prod;
    logic signed [2*DW:0]   rnd;
    logic signed [2*DW-FB:0] shr;
    logic signed [DW-1:0]   n_p;
    logic signed [DW-1:0]   r_p;

    always_comb begin
        prod = i_a * i_b;
        rnd  = (2*DW+1)'(prod) + ((2*DW+1)'(1) <<< (FB-1));
        shr  = rnd[2*DW:FB];
        if (shr > (2*DW-FB+1)'(VAL_MAX))
            n_p = VAL_MAX;
        else if (shr < (2*DW-FB+1)'(VAL_MIN))
            n_p = VAL_MIN;
        else
            n_p = shr[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/rap_div.sv =====
// restoring divider, one quotient bit per cycle
module rap_div
    import rap_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DIVW-1:0] i_dividend,
    input  logic [DVSW-1:0] i_divisor,
    output logic            o_done,
    output logic [DIVW-1:0] o_quot
);

    localparam int CW = $clog2(DIVW + 1);

    logic [DVSW-1:0] r_rem;
    logic [DVSW-1:0] r_dvs;
    logic [DIVW-1:0] r_quo;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic [DVSW:0]   trial;
    logic            fits;

    always_comb begin
        trial = {r_rem, r_quo[DIVW-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quo  <= i_dividend;
            r_cnt  <= CW'(DIVW);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? DVSW'(trial - {1'b0, r_dvs}) : trial[DVSW-1:0];
            r_quo  <= {r_quo[DIVW-2:0], fits};
            r_cnt  <= r_cnt - CW'(1);
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
